/* sv/mhs_pkg.sv */
`default_nettype none
package mhs_pkg;
  localparam int BLOCK_BYTES = 16;
  localparam int ROUNDS      = 18;
  localparam int MIX_BYTES   = 48;
  localparam int TABLE_SIZE  = 256;
  localparam int MIX_AW      = $clog2(MIX_BYTES);
  localparam int TABLE_AW    = $clog2(TABLE_SIZE);

  typedef logic [7:0] byte_t;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_ABSORB = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;
endpackage
`default_nettype wire

/* sv/mhs_sbox_ram.sv */
`default_nettype none
module mhs_sbox_ram #(
  parameter int DEPTH = mhs_pkg::TABLE_SIZE,
  parameter int AW    = mhs_pkg::TABLE_AW
) (
  input  wire            clk,
  input  wire            we,
  input  wire  [AW-1:0]  waddr,
  input  wire  [7:0]     wdata,
  input  wire  [AW-1:0]  raddr,
  output logic [7:0]     rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/mhs_mix_ram.sv */
`default_nettype none
module mhs_mix_ram #(
  parameter int DEPTH = mhs_pkg::MIX_BYTES,
  parameter int AW    = mhs_pkg::MIX_AW
) (
  input  wire            clk,
  input  wire            we,
  input  wire  [AW-1:0]  waddr,
  input  wire  [7:0]     wdata,
  input  wire  [AW-1:0]  raddr,
  output logic [7:0]     rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/md2_style_hash_top.sv */
`default_nettype none
// Load: table RAM write on acceptance. Absorb: states ABS0, ABS1, ABS2, plus compression on every 16th byte
// (one dependent substitution lookup per cycle through the table RAM read port).
// Finish: padding absorbs, checksum block setup into the mixing RAM, compression,
// then 16 digest transactions (states ORD, OLD, OWT for each), then a clear of all 48 bytes
// of the mixing RAM.
// Reset (rst_n low, synchronous) clears control and runs the clearing pass.
module md2_style_hash_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // table_index[7:0], table_value[15:8], data_byte[23:16]
  input  wire  [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // digest_byte[7:0], byte_position[11:8], zero[15:12]
  output logic        out_tlast   // last_byte
);
  localparam int MAW = mhs_pkg::MIX_AW;
  localparam logic [MAW-1:0] K_LAST = MAW'(mhs_pkg::MIX_BYTES - 1);
  localparam logic [4:0] R_LAST = 5'(mhs_pkg::ROUNDS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ABS0 = 4'd1;
  localparam logic [3:0] S_ABS1 = 4'd2;
  localparam logic [3:0] S_ABS2 = 4'd3;
  localparam logic [3:0] S_CMP0 = 4'd4;
  localparam logic [3:0] S_CMP1 = 4'd5;
  localparam logic [3:0] S_CK0  = 4'd6;
  localparam logic [3:0] S_CK1  = 4'd7;
  localparam logic [3:0] S_CK2  = 4'd8;
  localparam logic [3:0] S_ORD  = 4'd9;
  localparam logic [3:0] S_OLD  = 4'd10;
  localparam logic [3:0] S_OWT  = 4'd11;
  localparam logic [3:0] S_CLR  = 4'd12;

  logic [3:0]          state_r, state_nxt;
  logic [3:0]          fill_r, fill_nxt;
  logic [MAW-1:0]      k_r, k_nxt;
  logic [4:0]          r_r, r_nxt;
  logic                fin_r, fin_nxt;
  logic                cks_r, cks_nxt;
  mhs_pkg::byte_t      link_r, link_nxt;
  mhs_pkg::byte_t      b_r, b_nxt;
  mhs_pkg::byte_t      m_r, m_nxt;
  mhs_pkg::byte_t      cs_r [mhs_pkg::BLOCK_BYTES];
  logic                cs_we, cs_clr;
  mhs_pkg::byte_t      cs_wdata;
  logic                out_valid_r, out_valid_nxt;
  mhs_pkg::byte_t      out_byte_r;
  logic                out_ld;

  // memory ports
  logic                sb_we;
  logic [7:0]          sb_raddr;
  mhs_pkg::byte_t      sb_q;
  logic                mx_we;
  logic [MAW-1:0]      mx_waddr, mx_raddr;
  mhs_pkg::byte_t      mx_wdata, mx_q;

  mhs_pkg::byte_t      tn, tt, cs_cur;
  logic                in_acc;

  mhs_sbox_ram u_sbox (
    .clk   (clk),
    .we    (sb_we),
    .waddr (in_tdata[7:0]),
    .wdata (in_tdata[15:8]),
    .raddr (sb_raddr),
    .rdata (sb_q)
  );

  mhs_mix_ram #(.DEPTH(mhs_pkg::MIX_BYTES), .AW(MAW)) u_mix (
    .clk   (clk),
    .we    (mx_we),
    .waddr (mx_waddr),
    .wdata (mx_wdata),
    .raddr (mx_raddr),
    .rdata (mx_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign sb_we      = in_acc && (in_tuser == mhs_pkg::CMD_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, fill_r, out_byte_r};
  assign out_tlast  = (fill_r == 4'd15);

  assign cs_cur = cs_r[fill_r];
  assign tn     = mx_q ^ sb_q;
  assign tt     = (k_r == K_LAST) ? (tn + {3'd0, r_r}) : tn;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    r_nxt         = r_r;
    fin_nxt       = fin_r;
    cks_nxt       = cks_r;
    link_nxt      = link_r;
    b_nxt         = b_r;
    m_nxt         = m_r;
    out_valid_nxt = out_valid_r;
    out_ld        = 1'b0;
    cs_we         = 1'b0;
    cs_clr        = 1'b0;
    cs_wdata      = sb_q ^ cs_cur;
    sb_raddr      = 8'd0;
    mx_raddr      = {2'b00, fill_r};
    mx_we         = 1'b0;
    mx_waddr      = k_r;
    mx_wdata      = 8'd0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            mhs_pkg::CMD_ABSORB: begin
              b_nxt     = in_tdata[23:16];
              state_nxt = S_ABS0;
            end
            mhs_pkg::CMD_FINISH: begin
              fin_nxt = 1'b1;
              if (fill_r != 4'd0) begin
                b_nxt     = 8'(5'd16 - {1'b0, fill_r});
                state_nxt = S_ABS0;
              end else begin
                state_nxt = S_CK0;
              end
            end
            default: ;
          endcase
        end
      end
      S_ABS0: begin
        // read table at byte ^ link and the low state byte
        sb_raddr  = b_r ^ link_r;
        state_nxt = S_ABS1;
      end
      S_ABS1: begin
        link_nxt  = cs_wdata;
        cs_we     = 1'b1;
        m_nxt     = mx_q;
        mx_we     = 1'b1;
        mx_waddr  = {2'b01, fill_r};
        mx_wdata  = b_r;
        state_nxt = S_ABS2;
      end
      S_ABS2: begin
        mx_we    = 1'b1;
        mx_waddr = {2'b10, fill_r};
        mx_wdata = b_r ^ m_r;
        fill_nxt = fill_r + 4'd1;
        if (fill_r == 4'd15) begin
          state_nxt = S_CMP0;
        end else if (fin_r) begin
          state_nxt = S_ABS0;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_CMP0: begin
        // prime the first lookup: t = 0, k = 0
        k_nxt     = '0;
        r_nxt     = '0;
        sb_raddr  = 8'd0;
        mx_raddr  = '0;
        state_nxt = S_CMP1;
      end
      S_CMP1: begin
        mx_we    = 1'b1;
        mx_waddr = k_r;
        mx_wdata = tn;
        sb_raddr = tt;
        if (k_r == K_LAST) begin
          k_nxt    = '0;
          mx_raddr = '0;
          if (r_r == R_LAST) begin
            if (cks_r) begin
              state_nxt = S_ORD;
            end else if (fin_r) begin
              state_nxt = S_CK0;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            r_nxt = r_r + 5'd1;
          end
        end else begin
          k_nxt    = k_r + MAW'(1);
          mx_raddr = k_r + MAW'(1);
        end
      end
      S_CK0: begin
        state_nxt = S_CK1;
      end
      S_CK1: begin
        m_nxt     = mx_q;
        mx_we     = 1'b1;
        mx_waddr  = {2'b01, fill_r};
        mx_wdata  = cs_cur;
        state_nxt = S_CK2;
      end
      S_CK2: begin
        mx_we    = 1'b1;
        mx_waddr = {2'b10, fill_r};
        mx_wdata = cs_cur ^ m_r;
        fill_nxt = fill_r + 4'd1;
        if (fill_r == 4'd15) begin
          cks_nxt   = 1'b1;
          state_nxt = S_CMP0;
        end else begin
          state_nxt = S_CK0;
        end
      end
      S_ORD: begin
        state_nxt = S_OLD;
      end
      S_OLD: begin
        out_ld        = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_OWT;
      end
      S_OWT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          fill_nxt      = fill_r + 4'd1;
          if (fill_r == 4'd15) begin
            k_nxt     = '0;
            state_nxt = S_CLR;
          end else begin
            state_nxt = S_ORD;
          end
        end
      end
      S_CLR: begin
        // sweep the mixing RAM to zero, drop message state
        cs_clr   = 1'b1;
        link_nxt = 8'd0;
        fin_nxt  = 1'b0;
        cks_nxt  = 1'b0;
        fill_nxt = 4'd0;
        mx_we    = 1'b1;
        mx_waddr = k_r;
        mx_wdata = 8'd0;
        if (k_r == K_LAST) begin
          k_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt = k_r + MAW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      fill_r      <= 4'd0;
      k_r         <= '0;
      r_r         <= '0;
      fin_r       <= 1'b0;
      cks_r       <= 1'b0;
      link_r      <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      r_r         <= r_nxt;
      fin_r       <= fin_nxt;
      cks_r       <= cks_nxt;
      link_r      <= link_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checksum registers: cleared at once on reset and during the clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n || cs_clr) begin
      for (int i = 0; i < mhs_pkg::BLOCK_BYTES; i++) begin
        cs_r[i] <= 8'd0;
      end
    end else if (cs_we) begin
      cs_r[fill_r] <= cs_wdata;
    end
  end

  always_ff @(posedge clk) begin
    b_r <= b_nxt;
    m_r <= m_nxt;
    if (out_ld) begin
      out_byte_r <= mx_q;
    end
  end
endmodule
`default_nettype wire

/* dv/md2_hash_checker.sv */
`timescale 1ns / 1ps
module md2_hash_checker (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  input  wire        in_tready,
  input  wire [23:0] in_tdata,
  input  wire [1:0]  in_tuser,
  input  wire        out_tvalid,
  input  wire        out_tready,
  input  wire [15:0] out_tdata,
  input  wire        out_tlast,
  output int         errors,
  output int         digests_pending
);
  typedef struct packed {
    logic           last;
    logic [3:0]     pos;
    mhs_pkg::byte_t value;
  } digest_beat_t;

  mhs_pkg::byte_t sub_table [mhs_pkg::TABLE_SIZE];
  mhs_pkg::byte_t csum [mhs_pkg::BLOCK_BYTES];
  mhs_pkg::byte_t link;
  mhs_pkg::byte_t mix [mhs_pkg::MIX_BYTES];
  int             fill;
  digest_beat_t   digest_q [$];

  assign digests_pending = digest_q.size();

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void mix_rounds();
    mhs_pkg::byte_t t;
    t = 0;
    for (int r = 0; r < mhs_pkg::ROUNDS; r++) begin
      for (int k = 0; k < mhs_pkg::MIX_BYTES; k++) begin
        t = mix[k] ^ sub_table[t];
        mix[k] = t;
      end
      t = t + mhs_pkg::byte_t'(r);
    end
  endfunction

  function automatic void take_byte(input mhs_pkg::byte_t b);
    link = sub_table[b ^ link] ^ csum[fill];
    csum[fill] = link;
    mix[16 + fill] = b;
    mix[32 + fill] = b ^ mix[fill];
    fill++;
    if (fill == mhs_pkg::BLOCK_BYTES) begin
      mix_rounds();
      fill = 0;
    end
  endfunction

  function automatic void clear_msg();
    foreach (csum[i]) csum[i] = 0;
    foreach (mix[i]) mix[i] = 0;
    link = 0;
    fill = 0;
  endfunction

  function automatic void close_msg();
    mhs_pkg::byte_t pad;
    digest_beat_t beat;
    if (fill != 0) begin
      pad = mhs_pkg::byte_t'(mhs_pkg::BLOCK_BYTES - fill);
      do take_byte(pad); while (fill != 0);
    end
    for (int j = 0; j < mhs_pkg::BLOCK_BYTES; j++) begin
      mix[16 + j] = csum[j];
      mix[32 + j] = csum[j] ^ mix[j];
    end
    mix_rounds();
    for (int j = 0; j < mhs_pkg::BLOCK_BYTES; j++) begin
      beat.value = mix[j];
      beat.pos   = 4'(j);
      beat.last  = (j == mhs_pkg::BLOCK_BYTES - 1);
      digest_q.push_back(beat);
    end
    clear_msg();
  endfunction

  initial begin
    errors = 0;
    foreach (sub_table[i]) sub_table[i] = 0;
    clear_msg();
  end

  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && in_tvalid && in_tready) begin
      case (in_tuser)
        mhs_pkg::CMD_LOAD:   sub_table[in_tdata[7:0]] = in_tdata[15:8];
        mhs_pkg::CMD_ABSORB: take_byte(in_tdata[23:16]);
        mhs_pkg::CMD_FINISH: close_msg();
        default: ;
      endcase
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        report("unexpected digest byte", out_tdata, 0);
      end else begin
        want = digest_q.pop_front();
        if (out_tdata[7:0] != want.value) report("digest_byte", out_tdata[7:0], want.value);
        if (out_tdata[11:8] != want.pos) report("byte_position", out_tdata[11:8], want.pos);
        if (out_tdata[15:12] != 0) report("tdata pad", out_tdata[15:12], 0);
        if (out_tlast != want.last) report("last_byte", out_tlast, want.last);
      end
    end
  end
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  localparam logic [1:0] CMD_BAD = 2'd3;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = 0;   // table_index, table_value, data_byte from the lowest bit up
  logic [1:0]  in_tuser = 0;   // command
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [15:0] out_tdata;      // digest_byte, byte_position, zero
  logic        out_tlast;
  int          errors;
  int          pending;
  bit          hold_off = 0;   // long receiver stall in progress
  bit          stim_done = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  md2_style_hash_top DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  md2_hash_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast,
    .errors(errors), .digests_pending(pending)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 10);
    if ($urandom_range(2) == 0) return 0;
    return $urandom_range(3);
  endfunction

  // Offer one transaction at the falling edge, hold until accepted.
  task automatic send(input logic [1:0] cmd, input mhs_pkg::byte_t idx,
                      input mhs_pkg::byte_t val, input mhs_pkg::byte_t data);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tuser  <= cmd;
    in_tdata  <= {data, val, idx};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic load(input mhs_pkg::byte_t idx, input mhs_pkg::byte_t val);
    send(mhs_pkg::CMD_LOAD, idx, val, mhs_pkg::byte_t'($urandom));
  endtask

  task automatic absorb(input mhs_pkg::byte_t b);
    send(mhs_pkg::CMD_ABSORB, mhs_pkg::byte_t'($urandom), mhs_pkg::byte_t'($urandom), b);
  endtask

  task automatic finish_msg();
    send(mhs_pkg::CMD_FINISH, mhs_pkg::byte_t'($urandom), mhs_pkg::byte_t'($urandom),
         mhs_pkg::byte_t'($urandom));
  endtask

  // Receiver: random stalls, and the long hold-off when asked.
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 0;
      end else begin
        g = ($urandom_range(3) == 0) ? gap_len() : 0;
        if (g > 0) begin
          out_tready <= 0;
          repeat (g) @(negedge clk);
        end
        out_tready <= 1;
      end
    end
  end

  initial begin
    int len;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Write every entry so no lookup ever hits an unwritten one.
    for (int i = 0; i < 256; i++) load(mhs_pkg::byte_t'(i), mhs_pkg::byte_t'(i ^ 8'hff));
    finish_msg();                          // empty message, no padding
    absorb(8'h00); absorb(8'hff); finish_msg();            // partial block padding
    for (int i = 0; i < 16; i++) absorb(mhs_pkg::byte_t'(i * 17)); // exact block
    finish_msg();
    send(CMD_BAD, 8'hff, 8'hff, 8'hff);    // unknown command, ignored
    absorb(8'hAA); absorb(8'h55);
    send(CMD_BAD, 8'h00, 8'h00, 8'h00);
    finish_msg();
    load(8'h00, 8'hff); load(8'hff, 8'h00);  // rewrite two entries with the values they already hold
    for (int i = 0; i < 15; i++) absorb(8'hff);
    finish_msg();

    // Long receiver stall while further messages wait at the blocked input.
    fork
      begin
        hold_off = 1;
        repeat (4000) @(negedge clk);
        hold_off = 0;
      end
      for (int m = 0; m < 3; m++) begin
        absorb(mhs_pkg::byte_t'($urandom)); finish_msg();
      end
    join

    // Random messages, mostly short, a few spanning several blocks.
    for (int m = 0; m < 4; m++) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(40, 17) : $urandom_range(16);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(15) == 0) begin
          send(CMD_BAD, mhs_pkg::byte_t'($urandom), mhs_pkg::byte_t'($urandom),
               mhs_pkg::byte_t'($urandom));
        end else if ($urandom_range(20) == 0) begin
          load(mhs_pkg::byte_t'($urandom), mhs_pkg::byte_t'($urandom));
        end
        absorb(mhs_pkg::byte_t'($urandom));
      end
      finish_msg();
    end
    in_tvalid <= 0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_top: errors");
    $finish;
  end
endmodule

/* md2_style_hash_top.f */
sv/mhs_pkg.sv
sv/mhs_sbox_ram.sv
sv/mhs_mix_ram.sv
sv/md2_style_hash_top.sv
dv/md2_hash_checker.sv
dv/tb_top.sv
